@@ rtl/core/tdbpe_pkg.sv @@
`default_nettype none

package tdbpe_pkg;

   localparam int unsigned LEN_W  = 28;
   localparam int unsigned CNT_W  = 16;
   localparam int unsigned REG_W  = 16;
   localparam int unsigned NBIT_W = 4;

   localparam logic [REG_W-1:0] STD_PILOT_LEN    = 16'd2168;
   localparam logic [REG_W-1:0] STD_SYNC1_LEN    = 16'd667;
   localparam logic [REG_W-1:0] STD_SYNC2_LEN    = 16'd735;
   localparam logic [REG_W-1:0] STD_ZERO_LEN     = 16'd855;
   localparam logic [REG_W-1:0] STD_ONE_LEN      = 16'd1710;
   localparam logic [CNT_W-1:0] STD_PILOT_HEADER = 16'd8063;
   localparam logic [CNT_W-1:0] STD_PILOT_DATA   = 16'd3223;
   localparam logic [11:0]      TSTATES_PER_MS   = 12'd3500;
   localparam logic [7:0]       DATA_FLAG_LIMIT  = 8'd128;
   localparam logic [REG_W-1:0] RESET_PAUSE_MS   = 16'd1000;
   localparam logic [NBIT_W-1:0] BITS_PER_BYTE   = 4'd8;
   localparam logic [NBIT_W-1:0] MIN_BITS        = 4'd1;

   typedef enum logic [2:0] {
      KIND_PILOT = 3'd0,
      KIND_SYNC1 = 3'd1,
      KIND_SYNC2 = 3'd2,
      KIND_BIT   = 3'd3,
      KIND_PAUSE = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      CSR_TURBO_MODE    = 3'd0,
      CSR_PILOT_LEN     = 3'd1,
      CSR_PILOT_COUNT   = 3'd2,
      CSR_SYNC_FIRST    = 3'd3,
      CSR_SYNC_SECOND   = 3'd4,
      CSR_ZERO_BIT_LEN  = 3'd5,
      CSR_ONE_BIT_LEN   = 3'd6,
      CSR_PAUSE_MS      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic     load;
      logic     emit;
      kind_type kind;
      logic     last;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic pause_nz;
      logic bit_final;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/core/tdbpe_ctrl.sv @@
`default_nettype none

module tdbpe_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_first_of_block,
   output logic                       req_ready,
   input  wire tdbpe_pkg::status_type status,
   output tdbpe_pkg::cmd_type         cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PILOT = 6'b000010,
      ST_SYNC1 = 6'b000100,
      ST_SYNC2 = 6'b001000,
      ST_BIT   = 6'b010000,
      ST_PAUSE = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.kind  = tdbpe_pkg::KIND_PILOT;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               state_in = req_first_of_block ? ST_PILOT : ST_BIT;
            end
         end
         ST_PILOT: begin
            cmd.kind = tdbpe_pkg::KIND_PILOT;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_SYNC1;
            end
         end
         ST_SYNC1: begin
            cmd.kind = tdbpe_pkg::KIND_SYNC1;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_SYNC2;
            end
         end
         ST_SYNC2: begin
            cmd.kind = tdbpe_pkg::KIND_SYNC2;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_BIT;
            end
         end
         ST_BIT: begin
            cmd.kind = tdbpe_pkg::KIND_BIT;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.bit_final) begin
                  if (status.last && status.pause_nz) begin
                     state_in = ST_PAUSE;
                  end else begin
                     cmd.last = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_PAUSE: begin
            cmd.kind = tdbpe_pkg::KIND_PAUSE;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/tdbpe_dp.sv @@
`default_nettype none

module tdbpe_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tdbpe_pkg::cmd_type            cmd,
   output tdbpe_pkg::status_type              status,
   input  wire logic                          csr_wr_en,
   input  wire logic [2:0]                    csr_index,
   input  wire logic [tdbpe_pkg::REG_W-1:0]   csr_wdata,
   input  wire logic [7:0]                    req_data_byte,
   input  wire logic                          req_last_of_block,
   input  wire logic [3:0]                    req_used_bits,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic [tdbpe_pkg::LEN_W-1:0]        rsp_pulse_length,
   output logic [tdbpe_pkg::CNT_W-1:0]        rsp_repeat_count,
   output logic                               rsp_level_toggles,
   output logic [2:0]                         rsp_pulse_kind,
   output logic                               rsp_last_result
);

   logic                            turbo_ff;
   logic [tdbpe_pkg::REG_W-1:0]     pilot_len_ff;
   logic [tdbpe_pkg::CNT_W-1:0]     pilot_count_ff;
   logic [tdbpe_pkg::REG_W-1:0]     sync_first_ff;
   logic [tdbpe_pkg::REG_W-1:0]     sync_second_ff;
   logic [tdbpe_pkg::REG_W-1:0]     zero_len_ff;
   logic [tdbpe_pkg::REG_W-1:0]     one_len_ff;
   logic [tdbpe_pkg::REG_W-1:0]     pause_ms_ff;

   logic [7:0]                      byte_ff, byte_in;
   logic                            last_ff, last_in;
   logic [tdbpe_pkg::NBIT_W-1:0]    bits_left_ff, bits_left_in;
   logic                            half_ff, half_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tdbpe_pkg::LEN_W-1:0]     length_ff, length_in;
   logic [tdbpe_pkg::CNT_W-1:0]     repeat_ff, repeat_in;
   logic                            toggles_ff, toggles_in;
   tdbpe_pkg::kind_type             kind_ff, kind_in;
   logic                            last_result_ff, last_result_in;

   logic [tdbpe_pkg::NBIT_W-1:0]    nbits;
   logic [tdbpe_pkg::CNT_W-1:0]     pilot_count;
   logic [tdbpe_pkg::REG_W-1:0]     bit_len;
   logic [tdbpe_pkg::LEN_W-1:0]     pause_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         turbo_ff       <= 1'b0;
         pilot_len_ff   <= tdbpe_pkg::STD_PILOT_LEN;
         pilot_count_ff <= tdbpe_pkg::STD_PILOT_HEADER;
         sync_first_ff  <= tdbpe_pkg::STD_SYNC1_LEN;
         sync_second_ff <= tdbpe_pkg::STD_SYNC2_LEN;
         zero_len_ff    <= tdbpe_pkg::STD_ZERO_LEN;
         one_len_ff     <= tdbpe_pkg::STD_ONE_LEN;
         pause_ms_ff    <= tdbpe_pkg::RESET_PAUSE_MS;
      end else if (csr_wr_en) begin
         unique case (tdbpe_pkg::csr_index_type'(csr_index))
            tdbpe_pkg::CSR_TURBO_MODE:   turbo_ff       <= csr_wdata[0];
            tdbpe_pkg::CSR_PILOT_LEN:    pilot_len_ff   <= csr_wdata;
            tdbpe_pkg::CSR_PILOT_COUNT:  pilot_count_ff <= csr_wdata;
            tdbpe_pkg::CSR_SYNC_FIRST:   sync_first_ff  <= csr_wdata;
            tdbpe_pkg::CSR_SYNC_SECOND:  sync_second_ff <= csr_wdata;
            tdbpe_pkg::CSR_ZERO_BIT_LEN: zero_len_ff    <= csr_wdata;
            tdbpe_pkg::CSR_ONE_BIT_LEN:  one_len_ff     <= csr_wdata;
            tdbpe_pkg::CSR_PAUSE_MS:     pause_ms_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      nbits = tdbpe_pkg::BITS_PER_BYTE;
      if (turbo_ff && req_last_of_block) begin
         if (req_used_bits == '0) begin
            nbits = tdbpe_pkg::MIN_BITS;
         end else if (req_used_bits > tdbpe_pkg::BITS_PER_BYTE) begin
            nbits = tdbpe_pkg::BITS_PER_BYTE;
         end else begin
            nbits = req_used_bits;
         end
      end
   end

   always_comb begin
      if (turbo_ff) begin
         pilot_count = (pilot_count_ff == '0) ? tdbpe_pkg::CNT_W'(1) : pilot_count_ff;
      end else if (byte_ff >= tdbpe_pkg::DATA_FLAG_LIMIT) begin
         pilot_count = tdbpe_pkg::STD_PILOT_DATA;
      end else begin
         pilot_count = tdbpe_pkg::STD_PILOT_HEADER;
      end
      if (byte_ff[7]) begin
         bit_len = turbo_ff ? one_len_ff : tdbpe_pkg::STD_ONE_LEN;
      end else begin
         bit_len = turbo_ff ? zero_len_ff : tdbpe_pkg::STD_ZERO_LEN;
      end
      pause_len = tdbpe_pkg::LEN_W'(pause_ms_ff) *
                  tdbpe_pkg::LEN_W'(tdbpe_pkg::TSTATES_PER_MS);
   end

   always_comb begin
      byte_in      = byte_ff;
      last_in      = last_ff;
      bits_left_in = bits_left_ff;
      half_in      = half_ff;
      if (cmd.load) begin
         byte_in      = req_data_byte;
         last_in      = req_last_of_block;
         bits_left_in = nbits;
         half_in      = 1'b0;
      end else if (cmd.emit && cmd.kind == tdbpe_pkg::KIND_BIT) begin
         if (half_ff) begin
            half_in      = 1'b0;
            byte_in      = {byte_ff[6:0], 1'b0};
            bits_left_in = bits_left_ff - tdbpe_pkg::NBIT_W'(1);
         end else begin
            half_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      length_in      = length_ff;
      repeat_in      = repeat_ff;
      toggles_in     = toggles_ff;
      kind_in        = kind_ff;
      last_result_in = last_result_ff;
      if (cmd.emit) begin
         rsp_valid_in   = 1'b1;
         kind_in        = cmd.kind;
         last_result_in = cmd.last;
         toggles_in     = (cmd.kind != tdbpe_pkg::KIND_PAUSE);
         repeat_in      = tdbpe_pkg::CNT_W'(1);
         unique case (cmd.kind)
            tdbpe_pkg::KIND_PILOT: begin
               length_in = tdbpe_pkg::LEN_W'(turbo_ff ? pilot_len_ff
                                                      : tdbpe_pkg::STD_PILOT_LEN);
               repeat_in = pilot_count;
            end
            tdbpe_pkg::KIND_SYNC1: begin
               length_in = tdbpe_pkg::LEN_W'(turbo_ff ? sync_first_ff
                                                      : tdbpe_pkg::STD_SYNC1_LEN);
            end
            tdbpe_pkg::KIND_SYNC2: begin
               length_in = tdbpe_pkg::LEN_W'(turbo_ff ? sync_second_ff
                                                      : tdbpe_pkg::STD_SYNC2_LEN);
            end
            tdbpe_pkg::KIND_BIT: begin
               length_in = tdbpe_pkg::LEN_W'(bit_len);
            end
            tdbpe_pkg::KIND_PAUSE: begin
               length_in = pause_len;
            end
            default: begin
               length_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff        <= byte_in;
      last_ff        <= last_in;
      bits_left_ff   <= bits_left_in;
      half_ff        <= half_in;
      length_ff      <= length_in;
      repeat_ff      <= repeat_in;
      toggles_ff     <= toggles_in;
      kind_ff        <= kind_in;
      last_result_ff <= last_result_in;
   end

   assign status.last      = last_ff;
   assign status.pause_nz  = (pause_ms_ff != '0);
   assign status.bit_final = half_ff && (bits_left_ff == tdbpe_pkg::NBIT_W'(1));
   assign status.out_free  = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pulse_length  = length_ff;
   assign rsp_repeat_count  = repeat_ff;
   assign rsp_level_toggles = toggles_ff;
   assign rsp_pulse_kind    = kind_ff;
   assign rsp_last_result   = last_result_ff;

endmodule

`default_nettype wire

@@ rtl/core/tape_data_block_pulse_encoder_top.sv @@
// Tape data block pulse encoder. Takes one block byte per word on req_ and
// emits the pulse words that encode it on rsp_: pilot (one word carrying its
// repeat count), two sync pulses on the first byte of a block, two pulses per
// bit MSB first, and a silent pause after the last byte when pause_ms is
// nonzero. Lengths are in T-states. A byte is loaded, then its 2 to 20 words
// follow; a new byte is accepted only after the last word of the previous one
// is emitted. The sequencer emits one word per cycle into a single output
// register, stalling while it is full and rsp_ready is low. Write the csr_
// registers only while no byte is in flight.
`default_nettype none

module tape_data_block_pulse_encoder_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [2:0]                  csr_index,
   input  wire logic [tdbpe_pkg::REG_W-1:0] csr_wdata,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [7:0]                  req_data_byte,
   input  wire logic                        req_first_of_block,
   input  wire logic                        req_last_of_block,
   input  wire logic [3:0]                  req_used_bits,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [tdbpe_pkg::LEN_W-1:0]      rsp_pulse_length,
   output logic [tdbpe_pkg::CNT_W-1:0]      rsp_repeat_count,
   output logic                             rsp_level_toggles,
   output logic [2:0]                       rsp_pulse_kind,
   output logic                             rsp_last_result
);

   tdbpe_pkg::cmd_type    cmd;
   tdbpe_pkg::status_type status;

   tdbpe_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_first_of_block (req_first_of_block),
      .req_ready          (req_ready),
      .status             (status),
      .cmd                (cmd)
   );

   tdbpe_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_data_byte     (req_data_byte),
      .req_last_of_block (req_last_of_block),
      .req_used_bits     (req_used_bits),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_pulse_length  (rsp_pulse_length),
      .rsp_repeat_count  (rsp_repeat_count),
      .rsp_level_toggles (rsp_level_toggles),
      .rsp_pulse_kind    (rsp_pulse_kind),
      .rsp_last_result   (rsp_last_result)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("encoder took a byte while the previous one was in flight");

   a_pause_closes_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pulse_kind == tdbpe_pkg::KIND_PAUSE)
         |-> (rsp_last_result && !rsp_level_toggles))
      else $error("pause word is not the silent final word of its byte");

   a_single_repeat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pulse_kind != tdbpe_pkg::KIND_PILOT)
         |-> (rsp_repeat_count == tdbpe_pkg::CNT_W'(1)))
      else $error("non-pilot word carries a repeat count other than one");

   a_pilot_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pulse_kind == tdbpe_pkg::KIND_PILOT)
         |-> (rsp_repeat_count != '0 && !rsp_last_result))
      else $error("pilot word has zero count or ends its byte");
`endif

endmodule

`default_nettype wire
